FILE: hw/rtl/bnpp_pkg.sv
package bnpp_pkg;

    localparam int PATTERN_DEPTH = 32;
    localparam int PTR_W = $clog2(PATTERN_DEPTH);
    localparam int POS_W = PTR_W + 1;
    localparam int HOLD_W = 4;
    localparam int FREQ_W = 16;
    localparam int RELOAD_W = 20;
    localparam int COMPARE_W = 19;
    localparam int FACTOR_W = 17;
    localparam int PROD_W = FREQ_W + FACTOR_W;

    localparam logic [FACTOR_W-1:0] SEMI_UP_Q16 = 17'd69433;
    localparam logic [FACTOR_W-1:0] SEMI_DOWN_Q16 = 17'd61858;
    localparam logic [RELOAD_W-1:0] TIMER_CLOCK_HZ = 20'd1000000;
    localparam int DIV_STEPS = RELOAD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd3000;
    localparam logic [RELOAD_W-1:0] RELOAD_RESET = 20'd332;
    localparam logic [COMPARE_W-1:0] COMPARE_RESET = 19'd166;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 4'd1;

    localparam logic [7:0] CHAR_END = 8'h00;
    localparam logic [7:0] CHAR_FLAT = "b";
    localparam logic [7:0] CHAR_SHARP = "#";

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TICK,
        ST_CHECK,
        ST_DECODE,
        ST_MOD_WAIT,
        ST_MOD_CHECK,
        ST_SCALE,
        ST_AGAIN,
        ST_DIV,
        ST_DIV_END,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic do_load;
        logic hold_dec;
        logic stop;
        logic decode;
        logic mod_mult;
        logic scale_apply;
        logic silence;
        logic div_init;
        logic div_step;
        logic div_end;
    } cmd_t;

    typedef struct packed {
        logic playing;
        logic hold_nz;
        logic at_end;
        logic mod_hit;
        logic again;
        logic freq_nz;
        logic div_last;
    } status_t;

    function automatic logic [HOLD_W-1:0] digit_hold(input logic [7:0] ch);
        logic [HOLD_W-1:0] h;
        unique case (ch)
            "1": h = 4'd1;
            "2": h = 4'd2;
            "4": h = 4'd4;
            "8": h = 4'd8;
            default: h = '0;
        endcase
        return h;
    endfunction

    function automatic logic [FREQ_W-1:0] note_freq(input logic [7:0] ch);
        logic [FREQ_W-1:0] f;
        unique case (ch)
            "A": f = 16'd1760;
            "B": f = 16'd1976;
            "C": f = 16'd1046;
            "D": f = 16'd1175;
            "E": f = 16'd1319;
            "F": f = 16'd1397;
            "G": f = 16'd1568;
            "X": f = 16'd3000;
            "M": f = 16'd2850;
            "L": f = 16'd2700;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

FILE: hw/rtl/buzzer_note_pattern_player.sv
// Buzzer note pattern player.
// Commands arrive on start with opcode, pattern_char and last_char; a transfer
// happens at a rising edge with start high and busy low. Opcode 0 stores one
// pattern character, and last_char commits the pattern and starts playback if it
// is not empty. Opcode 1 is a playback tick that walks the stored pattern.
// Every command produces one result, shown for one cycle with done high:
// tone_on, note_hz, reload_value, compare_value and busy_res. The values stay
// on the ports while the block is idle.
// A load goes from its transfer through a load state to its result, and busy
// drops after the result. An idle tick or one that only counts down a hold
// goes through a tick state instead. A tick that steps the pattern walks each
// character through check, decode and modifier states, adds a scale step when
// a flat or sharp follows it and a final check when it runs into the end of
// the pattern. When a note sounds, the restoring divider finds the timer period
// and the timer values are loaded. One command is in flight at a time.
// Reset clears the pattern length, stops playback and loads 3000 Hz with a
// reload of 332 and a compare of 166; the store contents stay undefined.
// The receiver cannot stall: a result is taken in its done cycle.
module buzzer_note_pattern_player (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                opcode,
    input  logic [7:0]                          pattern_char,
    input  logic                                last_char,
    output logic                                done,
    output logic                                tone_on,
    output logic [bnpp_pkg::FREQ_W-1:0]         note_hz,
    output logic [bnpp_pkg::RELOAD_W-1:0]       reload_value,
    output logic [bnpp_pkg::COMPARE_W-1:0]      compare_value,
    output logic                                busy_res
);

    bnpp_pkg::cmd_t    cmd;
    bnpp_pkg::status_t status;

    bnpp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    bnpp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .pattern_char  (pattern_char),
        .last_char     (last_char),
        .status        (status),
        .tone_on       (tone_on),
        .note_hz       (note_hz),
        .reload_value  (reload_value),
        .compare_value (compare_value),
        .busy_res      (busy_res)
    );

endmodule

FILE: hw/rtl/bnpp_ctrl.sv
module bnpp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              opcode,
    input  bnpp_pkg::status_t status,
    output bnpp_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done
);

    bnpp_pkg::state_t state_reg;
    bnpp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bnpp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bnpp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = opcode ? bnpp_pkg::ST_TICK : bnpp_pkg::ST_LOAD;
                end
            end
            bnpp_pkg::ST_LOAD:
            begin
                state_next = bnpp_pkg::ST_DONE;
            end
            bnpp_pkg::ST_TICK:
            begin
                if (!status.playing || status.hold_nz)
                begin
                    state_next = bnpp_pkg::ST_DONE;
                end
                else
                begin
                    state_next = bnpp_pkg::ST_CHECK;
                end
            end
            bnpp_pkg::ST_CHECK:
            begin
                state_next = status.at_end ? bnpp_pkg::ST_DONE : bnpp_pkg::ST_DECODE;
            end
            bnpp_pkg::ST_DECODE:
            begin
                state_next = bnpp_pkg::ST_MOD_WAIT;
            end
            bnpp_pkg::ST_MOD_WAIT:
            begin
                state_next = bnpp_pkg::ST_MOD_CHECK;
            end
            bnpp_pkg::ST_MOD_CHECK:
            begin
                state_next = status.mod_hit ? bnpp_pkg::ST_SCALE : bnpp_pkg::ST_AGAIN;
            end
            bnpp_pkg::ST_SCALE:
            begin
                state_next = bnpp_pkg::ST_AGAIN;
            end
            bnpp_pkg::ST_AGAIN:
            begin
                priority if (status.again)
                begin
                    state_next = bnpp_pkg::ST_CHECK;
                end
                else if (status.freq_nz)
                begin
                    state_next = bnpp_pkg::ST_DIV;
                end
                else
                begin
                    state_next = bnpp_pkg::ST_DONE;
                end
            end
            bnpp_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = bnpp_pkg::ST_DIV_END;
                end
            end
            bnpp_pkg::ST_DIV_END:
            begin
                state_next = bnpp_pkg::ST_DONE;
            end
            bnpp_pkg::ST_DONE:
            begin
                state_next = bnpp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bnpp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            bnpp_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                cmd.capture = start;
            end
            bnpp_pkg::ST_LOAD:
            begin
                cmd.do_load = 1'b1;
            end
            bnpp_pkg::ST_TICK:
            begin
                cmd.hold_dec = status.playing && status.hold_nz;
            end
            bnpp_pkg::ST_CHECK:
            begin
                cmd.stop = status.at_end;
            end
            bnpp_pkg::ST_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            bnpp_pkg::ST_MOD_WAIT:
            begin
            end
            bnpp_pkg::ST_MOD_CHECK:
            begin
                cmd.mod_mult = status.mod_hit;
            end
            bnpp_pkg::ST_SCALE:
            begin
                cmd.scale_apply = 1'b1;
            end
            bnpp_pkg::ST_AGAIN:
            begin
                cmd.div_init = !status.again && status.freq_nz;
                cmd.silence = !status.again && !status.freq_nz;
            end
            bnpp_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            bnpp_pkg::ST_DIV_END:
            begin
                cmd.div_end = 1'b1;
            end
            bnpp_pkg::ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: hw/rtl/bnpp_datapath.sv
module bnpp_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bnpp_pkg::cmd_t                      cmd,
    input  logic [7:0]                          pattern_char,
    input  logic                                last_char,
    output bnpp_pkg::status_t                   status,
    output logic                                tone_on,
    output logic [bnpp_pkg::FREQ_W-1:0]         note_hz,
    output logic [bnpp_pkg::RELOAD_W-1:0]       reload_value,
    output logic [bnpp_pkg::COMPARE_W-1:0]      compare_value,
    output logic                                busy_res
);

    logic [7:0] pattern_store [bnpp_pkg::PATTERN_DEPTH];
    logic [7:0] rd_data_reg;

    logic [7:0] char_reg;
    logic [7:0] char_next;
    logic       last_reg;
    logic       last_next;
    logic [bnpp_pkg::PROD_W-1:0] prod_reg;
    logic [bnpp_pkg::PROD_W-1:0] prod_next;
    logic [bnpp_pkg::RELOAD_W-1:0] quo_reg;
    logic [bnpp_pkg::RELOAD_W-1:0] quo_next;
    logic [bnpp_pkg::FREQ_W-1:0] rem_reg;
    logic [bnpp_pkg::FREQ_W-1:0] rem_next;

    logic [bnpp_pkg::PTR_W-1:0] length_reg;
    logic [bnpp_pkg::PTR_W-1:0] length_next;
    logic [bnpp_pkg::PTR_W-1:0] load_idx_reg;
    logic [bnpp_pkg::PTR_W-1:0] load_idx_next;
    logic                       load_ended_reg;
    logic                       load_ended_next;
    logic [bnpp_pkg::POS_W-1:0] pos_reg;
    logic [bnpp_pkg::POS_W-1:0] pos_next;
    logic [bnpp_pkg::HOLD_W-1:0] hold_reg;
    logic [bnpp_pkg::HOLD_W-1:0] hold_next;
    logic [bnpp_pkg::HOLD_W-1:0] last_hold_reg;
    logic [bnpp_pkg::HOLD_W-1:0] last_hold_next;
    logic [bnpp_pkg::FREQ_W-1:0] freq_reg;
    logic [bnpp_pkg::FREQ_W-1:0] freq_next;
    logic                        playing_reg;
    logic                        playing_next;
    logic                        tone_reg;
    logic                        tone_next;
    logic [bnpp_pkg::RELOAD_W-1:0] reload_reg;
    logic [bnpp_pkg::RELOAD_W-1:0] reload_next;
    logic [bnpp_pkg::COMPARE_W-1:0] compare_reg;
    logic [bnpp_pkg::COMPARE_W-1:0] compare_next;
    logic                        again_reg;
    logic                        again_next;
    logic [bnpp_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [bnpp_pkg::DIV_CNT_W-1:0] div_cnt_next;

    logic                       wr_en;
    logic [bnpp_pkg::PTR_W-1:0] idx_after_load;
    logic [bnpp_pkg::HOLD_W-1:0] digit;
    logic [bnpp_pkg::HOLD_W-1:0] hold_value;
    logic [bnpp_pkg::FREQ_W:0]   rem_shift;
    logic                        div_ge;
    logic [bnpp_pkg::FREQ_W:0]   scaled;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pattern_store[load_idx_reg] <= char_reg;
        end
        rd_data_reg <= pattern_store[pos_reg[bnpp_pkg::PTR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        prod_reg <= prod_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            load_idx_reg <= '0;
            load_ended_reg <= 1'b0;
            pos_reg <= bnpp_pkg::POS_W'(bnpp_pkg::PATTERN_DEPTH);
            hold_reg <= '0;
            last_hold_reg <= bnpp_pkg::HOLD_RESET;
            freq_reg <= bnpp_pkg::FREQ_RESET;
            playing_reg <= 1'b0;
            tone_reg <= 1'b0;
            reload_reg <= bnpp_pkg::RELOAD_RESET;
            compare_reg <= bnpp_pkg::COMPARE_RESET;
            again_reg <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            length_reg <= length_next;
            load_idx_reg <= load_idx_next;
            load_ended_reg <= load_ended_next;
            pos_reg <= pos_next;
            hold_reg <= hold_next;
            last_hold_reg <= last_hold_next;
            freq_reg <= freq_next;
            playing_reg <= playing_next;
            tone_reg <= tone_next;
            reload_reg <= reload_next;
            compare_reg <= compare_next;
            again_reg <= again_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    assign digit = bnpp_pkg::digit_hold(rd_data_reg);
    assign hold_value = (digit != '0) ? digit : last_hold_reg;
    assign rem_shift = {rem_reg, quo_reg[bnpp_pkg::RELOAD_W-1]};
    assign div_ge = rem_shift >= {1'b0, freq_reg};
    assign scaled = prod_reg[bnpp_pkg::PROD_W-1:bnpp_pkg::FREQ_W];

    always_comb
    begin
        char_next = char_reg;
        last_next = last_reg;
        prod_next = prod_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        length_next = length_reg;
        load_idx_next = load_idx_reg;
        load_ended_next = load_ended_reg;
        pos_next = pos_reg;
        hold_next = hold_reg;
        last_hold_next = last_hold_reg;
        freq_next = freq_reg;
        playing_next = playing_reg;
        tone_next = tone_reg;
        reload_next = reload_reg;
        compare_next = compare_reg;
        again_next = again_reg;
        div_cnt_next = div_cnt_reg;
        wr_en = 1'b0;
        idx_after_load = load_idx_reg;

        if (cmd.capture)
        begin
            char_next = pattern_char;
            last_next = last_char;
        end

        if (cmd.do_load)
        begin
            if (!load_ended_reg
                && (load_idx_reg != bnpp_pkg::PTR_W'(bnpp_pkg::PATTERN_DEPTH - 1)))
            begin
                if (char_reg == bnpp_pkg::CHAR_END)
                begin
                    load_ended_next = 1'b1;
                end
                else
                begin
                    wr_en = 1'b1;
                    idx_after_load = load_idx_reg + 1'b1;
                    load_idx_next = idx_after_load;
                end
            end
            if (last_reg)
            begin
                length_next = idx_after_load;
                load_idx_next = '0;
                load_ended_next = 1'b0;
                if (idx_after_load != '0)
                begin
                    pos_next = '0;
                    hold_next = '0;
                    playing_next = 1'b1;
                end
            end
        end

        if (cmd.hold_dec)
        begin
            hold_next = hold_reg - 1'b1;
        end

        if (cmd.stop)
        begin
            tone_next = 1'b0;
            playing_next = 1'b0;
        end

        if (cmd.decode)
        begin
            pos_next = pos_reg + 1'b1;
            hold_next = hold_value;
            last_hold_next = hold_value;
            again_next = digit != '0;
            if (digit == '0)
            begin
                freq_next = bnpp_pkg::note_freq(rd_data_reg);
            end
        end

        if (cmd.mod_mult)
        begin
            pos_next = pos_reg + 1'b1;
            prod_next = freq_reg * ((rd_data_reg == bnpp_pkg::CHAR_FLAT)
                                    ? bnpp_pkg::SEMI_DOWN_Q16 : bnpp_pkg::SEMI_UP_Q16);
        end

        if (cmd.scale_apply)
        begin
            freq_next = scaled[bnpp_pkg::FREQ_W] ? '1 : scaled[bnpp_pkg::FREQ_W-1:0];
        end

        if (cmd.silence)
        begin
            tone_next = 1'b0;
        end

        if (cmd.div_init)
        begin
            quo_next = bnpp_pkg::TIMER_CLOCK_HZ;
            rem_next = '0;
            div_cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            rem_next = div_ge ? bnpp_pkg::FREQ_W'(rem_shift - {1'b0, freq_reg})
                              : rem_shift[bnpp_pkg::FREQ_W-1:0];
            quo_next = {quo_reg[bnpp_pkg::RELOAD_W-2:0], div_ge};
            div_cnt_next = div_cnt_reg + 1'b1;
        end

        if (cmd.div_end)
        begin
            reload_next = quo_reg - 1'b1;
            compare_next = quo_reg[bnpp_pkg::RELOAD_W-1:1];
            tone_next = 1'b1;
        end
    end

    assign status.playing = playing_reg;
    assign status.hold_nz = hold_reg != '0;
    assign status.at_end = pos_reg >= {1'b0, length_reg};
    assign status.mod_hit = (pos_reg < {1'b0, length_reg})
                            && ((rd_data_reg == bnpp_pkg::CHAR_FLAT)
                                || (rd_data_reg == bnpp_pkg::CHAR_SHARP));
    assign status.again = again_reg;
    assign status.freq_nz = freq_reg != '0;
    assign status.div_last = div_cnt_reg == bnpp_pkg::DIV_CNT_W'(bnpp_pkg::DIV_STEPS - 1);

    assign tone_on = tone_reg;
    assign note_hz = freq_reg;
    assign reload_value = reload_reg;
    assign compare_value = compare_reg;
    assign busy_res = playing_reg;

endmodule

FILE: hw/rtl/bnpp_checker.sv
module bnpp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic                                tone_on,
    input logic [bnpp_pkg::RELOAD_W-1:0]       reload_value,
    input logic [bnpp_pkg::COMPARE_W-1:0]      compare_value,
    input logic                                busy_res
);

    logic [bnpp_pkg::RELOAD_W:0] half_period;

    assign half_period = ({1'b0, reload_value} + 1'b1) >> 1;

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("Result strobe seen while the block was idle.");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Block did not go busy after a command transfer.");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("Block stayed busy after its result.");

    a_tone_needs_play: assert property (@(posedge clk) disable iff (!rst_n)
        tone_on |-> busy_res)
        else $error("Tone is on while no pattern is playing.");

    a_compare_half: assert property (@(posedge clk) disable iff (!rst_n)
        compare_value == half_period[bnpp_pkg::COMPARE_W-1:0])
        else $error("Compare value is not half of the timer period.");

endmodule

bind buzzer_note_pattern_player bnpp_checker u_bnpp_checker (.*);

FILE: sim/buzzer_note_pattern_player_tb.sv
`timescale 1ns / 100ps

module buzzer_note_pattern_player_tb;

    import bnpp_pkg::*;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;
    localparam int ITEM_COUNT = 1400;
    localparam int DRAIN_EVERY = 150;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 300;
    localparam int REPORT_CAP = 200;

    typedef struct {
        logic                 tone;
        logic [FREQ_W-1:0]    hz;
        logic [RELOAD_W-1:0]  reload;
        logic [COMPARE_W-1:0] compare;
        logic                 busy;
    } tone_result_t;

    class melody_scoreboard;
        logic [7:0]           store [PATTERN_DEPTH];
        logic [PTR_W-1:0]     pat_len;
        logic [PTR_W-1:0]     load_idx;
        bit                   load_ended;
        logic [POS_W-1:0]     position;
        logic [HOLD_W-1:0]    hold;
        logic [HOLD_W-1:0]    last_hold;
        logic [FREQ_W-1:0]    freq;
        bit                   playing;
        bit                   tone_en;
        logic [RELOAD_W-1:0]  reload;
        logic [COMPARE_W-1:0] compare;
        tone_result_t         expected_tones [$];
        int                   mismatches;
        int                   results;
        int                   loads;
        int                   ticks;
        int                   patterns;
        int                   saturations;

        function new();
            foreach (store[i])
                store[i] = '0;
            pat_len = '0;
            load_idx = '0;
            load_ended = 0;
            position = POS_W'(PATTERN_DEPTH);
            hold = '0;
            last_hold = HOLD_RESET;
            freq = FREQ_RESET;
            playing = 0;
            tone_en = 0;
            reload = RELOAD_RESET;
            compare = COMPARE_RESET;
        endfunction

        function logic [FREQ_W-1:0] semitone(logic [FREQ_W-1:0] f, logic [FACTOR_W-1:0] k);
            logic [PROD_W-1:0] p;
            p = f * k;
            p = p >> 16;
            if (p > 65535)
            begin
                saturations++;
                return '1;
            end
            return p[FREQ_W-1:0];
        endfunction

        function void store_char(logic [7:0] ch, logic last);
            if (!load_ended && load_idx < PATTERN_DEPTH - 1)
            begin
                if (ch == CHAR_END)
                    load_ended = 1;
                else
                begin
                    store[load_idx] = ch;
                    load_idx++;
                end
            end
            if (last)
            begin
                pat_len = load_idx;
                load_idx = '0;
                load_ended = 0;
                if (pat_len != 0)
                begin
                    position = '0;
                    hold = '0;
                    playing = 1;
                    patterns++;
                end
            end
        endfunction

        function void advance_melody();
            logic [7:0]          c;
            bit                  again;
            logic [RELOAD_W-1:0] period;
            if (!playing)
                return;
            if (hold != 0)
            begin
                hold--;
                return;
            end
            do
            begin
                if (position >= pat_len || position >= PATTERN_DEPTH)
                begin
                    tone_en = 0;
                    playing = 0;
                    return;
                end
                c = store[position[PTR_W-1:0]];
                position++;
                hold = last_hold;
                again = 0;
                case (c)
                    "1": begin hold = 4'd1; again = 1; end
                    "2": begin hold = 4'd2; again = 1; end
                    "4": begin hold = 4'd4; again = 1; end
                    "8": begin hold = 4'd8; again = 1; end
                    "A": freq = 16'd1760;
                    "B": freq = 16'd1976;
                    "C": freq = 16'd1046;
                    "D": freq = 16'd1175;
                    "E": freq = 16'd1319;
                    "F": freq = 16'd1397;
                    "G": freq = 16'd1568;
                    "X": freq = 16'd3000;
                    "M": freq = 16'd2850;
                    "L": freq = 16'd2700;
                    default: freq = '0;
                endcase
                last_hold = hold;
                if (position < pat_len && position < PATTERN_DEPTH)
                begin
                    if (store[position[PTR_W-1:0]] == CHAR_FLAT)
                    begin
                        freq = semitone(freq, SEMI_DOWN_Q16);
                        position++;
                    end
                    else if (store[position[PTR_W-1:0]] == CHAR_SHARP)
                    begin
                        freq = semitone(freq, SEMI_UP_Q16);
                        position++;
                    end
                end
            end
            while (again);
            if (freq != 0)
            begin
                period = TIMER_CLOCK_HZ / freq;
                reload = period - 1'b1;
                compare = period[RELOAD_W-1:1];
                tone_en = 1;
            end
            else
                tone_en = 0;
        endfunction

        function void note_command(logic op, logic [7:0] ch, logic last);
            tone_result_t r;
            if (op == OP_LOAD)
            begin
                loads++;
                store_char(ch, last);
            end
            else
            begin
                ticks++;
                advance_melody();
            end
            r.tone = tone_en;
            r.hz = freq;
            r.reload = reload;
            r.compare = compare;
            r.busy = playing;
            expected_tones.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("MISMATCH at %0t, result %0d: %s", $time, results, msg);
        endtask

        task check_tone(logic tone, logic [FREQ_W-1:0] hz, logic [RELOAD_W-1:0] rel,
                        logic [COMPARE_W-1:0] cmp, logic bsy);
            tone_result_t e;
            if (expected_tones.size() == 0)
            begin
                report_mismatch("result with no command outstanding");
                return;
            end
            e = expected_tones.pop_front();
            results++;
            if (tone !== e.tone)
                report_mismatch($sformatf("tone_on %0b, expected %0b", tone, e.tone));
            if (hz !== e.hz)
                report_mismatch($sformatf("note_hz %0d, expected %0d", hz, e.hz));
            if (rel !== e.reload)
                report_mismatch($sformatf("reload_value %0d, expected %0d", rel, e.reload));
            if (cmp !== e.compare)
                report_mismatch($sformatf("compare_value %0d, expected %0d", cmp, e.compare));
            if (bsy !== e.busy)
                report_mismatch($sformatf("busy_res %0b, expected %0b", bsy, e.busy));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 opcode = OP_LOAD;
    logic [7:0]           pattern_char = '0;
    logic                 last_char = 1'b0;
    logic                 done;
    logic                 tone_on;
    logic [FREQ_W-1:0]    note_hz;
    logic [RELOAD_W-1:0]  reload_value;
    logic [COMPARE_W-1:0] compare_value;
    logic                 busy_res;

    melody_scoreboard sb;
    bit               no_gaps = 0;
    int               quiet_cycles = 0;
    string            note_letters = "ABCDEFGXML";
    string            hold_digits = "1248";

    buzzer_note_pattern_player dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .pattern_char(pattern_char),
        .last_char(last_char),
        .done(done),
        .tone_on(tone_on),
        .note_hz(note_hz),
        .reload_value(reload_value),
        .compare_value(compare_value),
        .busy_res(busy_res)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_tone(tone_on, note_hz, reload_value, compare_value, busy_res);

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer and no result for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic issue_command(input logic op, input logic [7:0] ch, input logic last);
        int r;
        int gap;
        start <= 1'b1;
        opcode <= op;
        pattern_char <= ch;
        last_char <= last;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(op, ch, last);
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            gap = 0;
        else if (r < 88)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_tones.size() != 0);
    endtask

    function automatic logic [7:0] random_pattern_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return note_letters[$urandom_range(0, 9)];
        else if (r < 60)
            return hold_digits[$urandom_range(0, 3)];
        else if (r < 72)
            return $urandom_range(0, 1) ? CHAR_FLAT : CHAR_SHARP;
        else if (r < 74)
            return CHAR_END;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic play_pattern();
        int         n;
        int         r;
        bit         climb;
        logic [7:0] bend;
        logic [7:0] ch;
        r = $urandom_range(0, 99);
        climb = (r < 6);
        bend = ($urandom_range(0, 9) < 6) ? CHAR_SHARP : CHAR_FLAT;
        if (climb)
            n = 2 * $urandom_range(8, 15);
        else if (r < 85)
            n = $urandom_range(1, 10);
        else if (r < 97)
            n = $urandom_range(11, 31);
        else
            n = $urandom_range(32, 40);
        for (int i = 0; i < n; i++)
        begin
            if (climb)
                ch = (i % 2 == 0) ? hold_digits[$urandom_range(0, 3)] : bend;
            else
                ch = random_pattern_char();
            issue_command(OP_LOAD, ch, i == n - 1);
        end
        while (sb.playing)
        begin
            if ($urandom_range(0, 99) < 3)
                issue_command(OP_LOAD, random_pattern_char(), $urandom_range(0, 9) < 3);
            else
                issue_command(OP_TICK, 8'($urandom), 1'($urandom));
        end
        repeat ($urandom_range(0, 2))
            issue_command(OP_TICK, 8'($urandom), 1'($urandom));
    endtask

    initial
    begin
        int next_drain;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle tick, empty commit, then a short pattern with modifiers, a pause and
        // a trailing hold digit.
        issue_command(OP_TICK, 8'hFF, 1'b1);
        issue_command(OP_LOAD, CHAR_END, 1'b1);
        issue_command(OP_LOAD, "X", 1'b0);
        issue_command(OP_LOAD, CHAR_SHARP, 1'b0);
        issue_command(OP_LOAD, "1", 1'b0);
        issue_command(OP_LOAD, CHAR_FLAT, 1'b0);
        issue_command(OP_LOAD, 8'hFF, 1'b0);
        issue_command(OP_LOAD, "8", 1'b1);
        while (sb.playing)
            issue_command(OP_TICK, 8'h00, 1'b0);

        // A load while playing, a restart on commit, and an empty commit that stops
        // the pattern at its next step.
        issue_command(OP_LOAD, "A", 1'b0);
        issue_command(OP_LOAD, "B", 1'b1);
        issue_command(OP_TICK, 8'h00, 1'b0);
        issue_command(OP_LOAD, "C", 1'b0);
        issue_command(OP_TICK, 8'h00, 1'b0);
        issue_command(OP_LOAD, CHAR_END, 1'b1);
        issue_command(OP_TICK, 8'h00, 1'b0);
        issue_command(OP_LOAD, CHAR_END, 1'b1);
        issue_command(OP_TICK, 8'h00, 1'b0);
        issue_command(OP_TICK, 8'h00, 1'b0);
        wait_drained();

        next_drain = sb.loads + sb.ticks + DRAIN_EVERY;
        while (sb.loads + sb.ticks < ITEM_COUNT)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 80)
                play_pattern();
            else
                repeat ($urandom_range(1, 6))
                    issue_command(1'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
            if (sb.loads + sb.ticks >= next_drain)
            begin
                wait_drained();
                next_drain += DRAIN_EVERY;
            end
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d loads and %0d ticks, %0d patterns started, %0d results checked",
                 sb.loads, sb.ticks, sb.patterns, sb.results);
        $display("semitone saturations: %0d, mismatches: %0d", sb.saturations, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_tones.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: buzzer_note_pattern_player.f
hw/rtl/bnpp_pkg.sv
hw/rtl/bnpp_ctrl.sv
hw/rtl/bnpp_datapath.sv
hw/rtl/buzzer_note_pattern_player.sv
hw/rtl/bnpp_checker.sv
sim/buzzer_note_pattern_player_tb.sv
